// ===== rtl/wtmv_pkg.sv =====
package wtmv_pkg;

  // Map store geometry
  localparam int MAP_MAX_SIDE = 64;
  localparam int SIDE_W       = $clog2(MAP_MAX_SIDE);
  localparam int ADDR_W       = 2 * SIDE_W;
  localparam int MEM_DEPTH    = MAP_MAX_SIDE * MAP_MAX_SIDE;

  // Visible window
  localparam int VIEW_COLS = 20;
  localparam int VIEW_ROWS = 16;
  localparam int COL_W     = (VIEW_COLS > 1) ? $clog2(VIEW_COLS) : 1;

  localparam int KIND_OFFSET = 11;
  localparam int VEL_LIMIT   = 3;
  localparam int VEL_W       = 3;

  // Configuration
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SIZE_W     = 7;
  localparam int SIZE_RESET = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = CFG_IDX_W'(1);

  // Remainder unit: dividend covers camera + velocity + 3 * size
  localparam int DIV_W = 9;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_KEY   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_EMIT  = 2'd3;

  // Key codes
  localparam logic [1:0] KEY_UP    = 2'd0;
  localparam logic [1:0] KEY_DOWN  = 2'd1;
  localparam logic [1:0] KEY_LEFT  = 2'd2;
  localparam logic [1:0] KEY_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [2:0] resource_kind;
    logic [1:0] key_code;
    logic       key_down;
    logic [3:0] screen_row;
  } in_t;

  typedef struct packed {
    logic [4:0] tile_code;
    logic [4:0] screen_col;
    logic [5:0] camera_x;
    logic [5:0] camera_y;
    logic       last;
  } out_t;

endpackage

// ===== rtl/wtmv_rem.sv =====
module wtmv_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wtmv_pkg::DIV_W-1:0]  dividend_i,
  input  logic [wtmv_pkg::SIZE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [wtmv_pkg::SIDE_W-1:0] rem_o
);
  import wtmv_pkg::*;

  logic [DIV_W-1:0]  shift_q, shift_d;
  logic [SIDE_W-1:0] part_q, part_d;
  logic [SIZE_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SIDE_W:0]   trial;

  // Restoring remainder, one dividend bit a cycle
  always_comb begin
    shift_d = shift_q;
    part_d  = part_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    trial   = {part_q, shift_q[DIV_W-1]};
    if (start_i) begin
      shift_d = dividend_i;
      part_d  = '0;
      div_d   = divisor_i;
      cnt_d   = CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      shift_d = {shift_q[DIV_W-2:0], 1'b0};
      if (trial >= div_q) begin
        part_d = SIDE_W'(trial - div_q);
      end else begin
        part_d = SIDE_W'(trial);
      end
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    part_q  <= part_d;
    div_q   <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = part_q;

endmodule

// ===== rtl/wrapping_tile_map_viewport_unit.sv =====
// Toroidal tile-map scroller. After reset the block sweeps its 4096-entry tile
// store to zero, one entry a cycle, and takes no transaction on the input
// channel while it sweeps (configuration writes are taken at all times).
// Items are worked one at a time. A cell write or a key event is handled in
// the idle state. For a frame tick the wrapped camera position comes out of
// two restoring remainder units (one per axis), then one result is queued. A
// row request goes through the same wrap reduction and then reads VIEW_COLS
// tiles, one tile per cycle from the single tile memory read port; emission
// slows down only while the output side stalls. A row request whose
// screen_row is not below VIEW_ROWS gives no result. A two-entry output queue
// decouples the memory read from the result channel, so finished results
// wait there while the next item is accepted. Map sizes below 1 act as 1 and
// sizes above MAP_MAX_SIDE act as MAP_MAX_SIDE; cell writes outside the map
// in use are dropped.
module wrapping_tile_map_viewport_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wtmv_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wtmv_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wtmv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wtmv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wtmv_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_TICK  = 5'b01000,
    ST_ROW   = 5'b10000
  } state_e;

  function automatic logic signed [VEL_W-1:0] sat_add(logic signed [VEL_W-1:0] v,
                                                      logic signed [1:0] d);
    logic signed [VEL_W:0] s;
    s = {v[VEL_W-1], v} + {{(VEL_W-1){d[1]}}, d};
    if (s > (VEL_W+1)'(VEL_LIMIT)) begin
      s = (VEL_W+1)'(VEL_LIMIT);
    end else if (s < -(VEL_W+1)'(VEL_LIMIT)) begin
      s = -(VEL_W+1)'(VEL_LIMIT);
    end
    return s[VEL_W-1:0];
  endfunction

  // Tile store
  logic [4:0] tile_mem [MEM_DEPTH];

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  // Configuration and scroll state
  logic [SIZE_W-1:0]       map_w_q, map_h_q;
  logic [SIZE_W-1:0]       w_eff, h_eff;
  logic [SIDE_W-1:0]       cam_x_q, cam_x_d, cam_y_q, cam_y_d;
  logic signed [VEL_W-1:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [1:0]       key_delta;

  // Clearing sweep
  logic [ADDR_W-1:0] clr_q, clr_d;

  // Row walk
  logic [SIDE_W-1:0] x_q, x_d, y_q, y_d;
  logic [COL_W-1:0]  col_q, col_d;

  // Memory access
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [4:0]        mem_wdata;
  logic              issue;
  logic [4:0]        rdata_q;
  logic              pend_q;
  logic [COL_W-1:0]  rd_col_q;
  logic              rd_last_q;

  // Remainder units
  logic              rem_start;
  logic [DIV_W-1:0]  div_x, div_y;
  logic              done_x, done_y;
  logic [SIDE_W-1:0] rem_x, rem_y;

  // Output queue
  out_t       q_mem_q [2];
  logic       q_wr_q, q_rd_q;
  logic [1:0] occ_q;
  logic [1:0] inflight;
  logic       push, pop, tick_push;
  out_t       push_data;

  logic in_acc;
  in_t  item;

  assign item        = in_data_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Clamp map sizes to 1 .. MAP_MAX_SIDE
  always_comb begin
    w_eff = map_w_q;
    if (map_w_q == '0) begin
      w_eff = SIZE_W'(1);
    end else if (map_w_q > SIZE_W'(MAP_MAX_SIDE)) begin
      w_eff = SIZE_W'(MAP_MAX_SIDE);
    end
    h_eff = map_h_q;
    if (map_h_q == '0) begin
      h_eff = SIZE_W'(1);
    end else if (map_h_q > SIZE_W'(MAP_MAX_SIDE)) begin
      h_eff = SIZE_W'(MAP_MAX_SIDE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= SIZE_W'(SIZE_RESET);
      map_h_q <= SIZE_W'(SIZE_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_MAP_WIDTH) begin
        map_w_q <= cfg_data_i;
      end else if (cfg_index_i == REG_MAP_HEIGHT) begin
        map_h_q <= cfg_data_i;
      end
    end
  end

  // Wrap operands. A tick adds 3 * size so the sum never goes negative and
  // the remainder is the true modulo of camera + velocity.
  always_comb begin
    if (item.cmd == CMD_TICK) begin
      div_x = DIV_W'(cam_x_q) + DIV_W'(unsigned'(DIV_W'(vel_x_q)))
            + {DIV_W'(w_eff) << 1} + DIV_W'(w_eff);
      div_y = DIV_W'(cam_y_q) + DIV_W'(unsigned'(DIV_W'(vel_y_q)))
            + {DIV_W'(h_eff) << 1} + DIV_W'(h_eff);
    end else begin
      div_x = DIV_W'(cam_x_q);
      div_y = DIV_W'(cam_y_q) + DIV_W'(item.screen_row);
    end
  end

  assign rem_start = in_acc && ((item.cmd == CMD_TICK) ||
                     ((item.cmd == CMD_EMIT) && (32'(item.screen_row) < VIEW_ROWS)));

  wtmv_rem u_rem_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (div_x),
    .divisor_i  (w_eff),
    .done_o     (done_x),
    .rem_o      (rem_x)
  );

  wtmv_rem u_rem_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (div_y),
    .divisor_i  (h_eff),
    .done_o     (done_y),
    .rem_o      (rem_y)
  );

  // Issue a tile read only when the queue has room for it once it lands
  assign pop      = out_valid_o && !out_stall_i;
  assign inflight = occ_q + 2'(pend_q);
  assign issue    = (state_q == ST_ROW) && ((inflight < 2'd2) || ((inflight == 2'd2) && pop));

  assign key_delta = item.key_down ? 2'sd1 : -2'sd1;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    emit_d    = emit_q;
    clr_d     = clr_q;
    cam_x_d   = cam_x_q;
    cam_y_d   = cam_y_q;
    vel_x_d   = vel_x_q;
    vel_y_d   = vel_y_q;
    x_d       = x_q;
    y_d       = y_q;
    col_d     = col_q;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    tick_push = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (item.cmd)
            CMD_WRITE: begin
              // Drop writes outside the map in use
              if (({1'b0, item.cell_x} < w_eff) && ({1'b0, item.cell_y} < h_eff)) begin
                mem_we    = 1'b1;
                mem_waddr = {item.cell_y, item.cell_x};
                mem_wdata = 5'(item.resource_kind) + 5'(KIND_OFFSET);
              end
            end
            CMD_KEY: begin
              // Left/right are inverted on purpose
              case (item.key_code)
                KEY_UP:    vel_y_d = sat_add(vel_y_q, -key_delta);
                KEY_DOWN:  vel_y_d = sat_add(vel_y_q, key_delta);
                KEY_LEFT:  vel_x_d = sat_add(vel_x_q, key_delta);
                default:   vel_x_d = sat_add(vel_x_q, -key_delta);
              endcase
            end
            CMD_TICK: begin
              emit_d  = 1'b0;
              state_d = ST_MOD;
            end
            default: begin
              if (rem_start) begin
                emit_d  = 1'b1;
                state_d = ST_MOD;
              end
            end
          endcase
        end
      end
      ST_MOD: begin
        if (done_x && done_y) begin
          if (emit_q) begin
            x_d     = rem_x;
            y_d     = rem_y;
            col_d   = '0;
            state_d = ST_ROW;
          end else begin
            cam_x_d = rem_x;
            cam_y_d = rem_y;
            state_d = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        if (!pend_q && (occ_q < 2'd2)) begin
          tick_push = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_ROW: begin
        if (issue) begin
          // Advance x with wrap at the map width
          if ({1'b0, x_q} == w_eff - SIZE_W'(1)) begin
            x_d = '0;
          end else begin
            x_d = x_q + SIDE_W'(1);
          end
          col_d = col_q + COL_W'(1);
          if (col_q == COL_W'(VIEW_COLS - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      emit_q  <= 1'b0;
      clr_q   <= '0;
      cam_x_q <= '0;
      cam_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
      clr_q   <= clr_d;
      cam_x_q <= cam_x_d;
      cam_y_q <= cam_y_d;
      vel_x_q <= vel_x_d;
      vel_y_q <= vel_y_d;
      pend_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    col_q <= col_d;
    if (issue) begin
      rd_col_q  <= col_q;
      rd_last_q <= (col_q == COL_W'(VIEW_COLS - 1));
    end
  end

  // Tile memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_q <= tile_mem[{y_q, x_q}];
    end
  end

  // Output queue
  assign push = pend_q || tick_push;

  always_comb begin
    push_data.camera_x = cam_x_q;
    push_data.camera_y = cam_y_q;
    if (pend_q) begin
      push_data.tile_code  = rdata_q;
      push_data.screen_col = 5'(rd_col_q);
      push_data.last       = rd_last_q;
    end else begin
      push_data.tile_code  = '0;
      push_data.screen_col = '0;
      push_data.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q <= 1'b0;
      q_rd_q <= 1'b0;
      occ_q  <= '0;
    end else begin
      if (push) begin
        q_wr_q <= !q_wr_q;
      end
      if (pop) begin
        q_rd_q <= !q_rd_q;
      end
      occ_q <= occ_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_wr_q] <= push_data;
    end
  end

  assign out_valid_o = (occ_q != '0);
  assign out_data_o  = q_mem_q[q_rd_q];

endmodule

// ===== rtl/wtmv_checker.sv =====
module wtmv_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input wtmv_pkg::in_t                  in_data_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input wtmv_pkg::out_t                 out_data_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [wtmv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [wtmv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wtmv_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid_i ^ in_stall_o ^ (^in_data_i) ^ cfg_valid_i ^ (^cfg_index_i)
                   ^ (^cfg_data_i);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Only the final tile of a row or a tick result carries last
  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      (out_data_o.screen_col == 5'(VIEW_COLS - 1)) || (out_data_o.screen_col == 5'd0))
    else $error("last flag on an inner column");

  // Stored tiles are empty or a resource code
  a_tile_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.tile_code == 5'd0) ||
      ((out_data_o.tile_code >= 5'(KIND_OFFSET)) && (out_data_o.tile_code <= 5'(KIND_OFFSET + 7))))
    else $error("tile code out of range");

  // The configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind wrapping_tile_map_viewport_unit wtmv_checker u_wtmv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);
